// ===== sv/emhc_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants for the extruder motor and heater controller.
// No dependencies; emhc_core, the controller unit and the testbench import this package.
package emhc_pkg;

  typedef enum logic [1:0] {
    OP_COMMAND     = 2'd0,
    OP_HEAT_TICK   = 2'd1,
    OP_PIN_SAMPLE  = 2'd2,
    OP_TEMPERATURE = 2'd3
  } op_e;

  typedef enum logic [7:0] {
    CMD_VERSION     = 8'd0,
    CMD_RUN_FWD     = 8'd1,
    CMD_RUN_REV     = 8'd2,
    CMD_SETPOS      = 8'd3,
    CMD_POS_READ    = 8'd4,
    CMD_GOTO        = 8'd5,
    CMD_COAST       = 8'd6,
    CMD_ALERT_ADDR  = 8'd7,
    CMD_MAT_QUERY   = 8'd8,
    CMD_HEAT_CFG    = 8'd9,
    CMD_TEMP_READ   = 8'd10,
    CMD_FAN_SET     = 8'd11,
    CMD_PWM_PERIOD  = 8'd50
  } cmd_e;

  typedef enum logic [1:0] {
    MSG_NONE   = 2'd0,
    MSG_REPLY  = 2'd1,
    MSG_NOTIFY = 2'd2
  } msg_e;

  localparam logic [7:0] VERSION_HIGH  = 8'd2;
  localparam logic [7:0] BYTE_MAX      = 8'd255;
  localparam logic [7:0] PERIOD_RESET  = 8'd255;
  localparam logic [7:0] NOTIFY_RESET  = 8'd255;
  localparam logic [7:0] EMPTY_FLAG    = 8'd1;

  typedef struct packed {
    logic       fwd;
    logic       rev;
    logic       pwm_on;
    logic [7:0] duty;
    logic [7:0] period_now;
  } motor_t;

  localparam motor_t MOTOR_OFF = '{fwd: 1'b0, rev: 1'b0, pwm_on: 1'b0,
                                   duty: 8'd0, period_now: PERIOD_RESET};

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] command_code;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [7:0] arg_third;
    logic [7:0] arg_fourth;
    logic       opto_level;
    logic       material_level;
    logic [7:0] temperature_count;
    logic [7:0] reference_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] message_kind;
    logic [7:0] notify_target;
    logic [7:0] reply_kind;
    logic [7:0] reply_low;
    logic [7:0] reply_high;
    motor_t     motor;
    logic       heater_on;
    logic       cooler_on;
  } out_item_t;

  function automatic motor_t drive_f(logic [7:0] speed, logic dir, logic [7:0] period);
    motor_t m;
    if (speed == 8'd0) begin
      m = MOTOR_OFF;
    end else begin
      m.fwd        = ~dir;
      m.rev        = dir;
      m.pwm_on     = 1'b1;
      m.duty       = speed;
      m.period_now = (speed == BYTE_MAX) ? 8'd0 : period;
    end
    return m;
  endfunction

endpackage

// ===== sv/emhc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the extruder controller: valid/ready plus item fields.
// No dependencies.
interface emhc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] command_code;
  logic [7:0] arg_first;
  logic [7:0] arg_second;
  logic [7:0] arg_third;
  logic [7:0] arg_fourth;
  logic       opto_level;
  logic       material_level;
  logic [7:0] temperature_count;
  logic [7:0] reference_count;

  modport source (output valid, operation, command_code, arg_first, arg_second,
                  arg_third, arg_fourth, opto_level, material_level,
                  temperature_count, reference_count, input ready);
  modport sink (input valid, operation, command_code, arg_first, arg_second,
                arg_third, arg_fourth, opto_level, material_level,
                temperature_count, reference_count, output ready);
endinterface

// ===== sv/emhc_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the extruder controller: valid/ready plus result fields.
// No dependencies.
interface emhc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] message_kind;
  logic [7:0] notify_target;
  logic [7:0] reply_kind;
  logic [7:0] reply_low;
  logic [7:0] reply_high;
  logic       forward_enable;
  logic       reverse_enable;
  logic       pwm_enable;
  logic [7:0] pwm_duty;
  logic [7:0] pwm_period_now;
  logic       heater_on;
  logic       cooler_on;

  modport source (output valid, message_kind, notify_target, reply_kind, reply_low,
                  reply_high, forward_enable, reverse_enable, pwm_enable, pwm_duty,
                  pwm_period_now, heater_on, cooler_on, input ready);
  modport sink (input valid, message_kind, notify_target, reply_kind, reply_low,
                reply_high, forward_enable, reverse_enable, pwm_enable, pwm_duty,
                pwm_period_now, heater_on, cooler_on, output ready);
endinterface

// ===== sv/emhc_core.sv =====
`timescale 1ns / 1ps
// Controller state and the single-pass decision logic for one item.
// Depends on emhc_pkg.
module emhc_core #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  emhc_pkg::in_item_t item_i,
  output emhc_pkg::out_item_t result_o
);
  import emhc_pkg::*;

  localparam int PW = POSITION_WIDTH;

  logic          motor_reverse_q, motor_reverse_d;
  logic [7:0]    seek_rate_q, seek_rate_d;
  logic [7:0]    notify_addr_q, notify_addr_d;
  logic          prev_opto_q, prev_opto_d;
  logic          prev_mat_q, prev_mat_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] goal_q, goal_d;
  logic [7:0]    pow_low_q, pow_low_d;
  logic [7:0]    pow_cold_q, pow_cold_d;
  logic [7:0]    lim_med_q, lim_med_d;
  logic [7:0]    lim_crit_q, lim_crit_d;
  logic [7:0]    phase_q, phase_d;
  logic [7:0]    temp_q, temp_d;
  logic [7:0]    ref_q, ref_d;
  logic [7:0]    period_q, period_d;
  motor_t        motor_q, motor_d;
  logic          heater_q, heater_d;
  logic          cooler_q, cooler_d;

  logic [31:0]   set_wide;
  logic [31:0]   seek_wide;
  logic [31:0]   pos_wide;
  logic [PW-1:0] seek_goal;
  logic [PW-1:0] pos_step;
  logic          seek_dir;

  assign set_wide  = {16'd0, item_i.arg_second, item_i.arg_first};
  assign seek_wide = {16'd0, item_i.arg_third, item_i.arg_second};
  assign pos_wide  = 32'(pos_q);
  assign seek_goal = seek_wide[PW-1:0];
  assign seek_dir  = $signed(pos_q) > $signed(seek_goal);
  assign pos_step  = motor_reverse_q ? pos_q - PW'(1) : pos_q + PW'(1);

  always_comb begin
    motor_reverse_d = motor_reverse_q;
    seek_rate_d     = seek_rate_q;
    notify_addr_d   = notify_addr_q;
    prev_opto_d     = prev_opto_q;
    prev_mat_d      = prev_mat_q;
    pos_d           = pos_q;
    goal_d          = goal_q;
    pow_low_d       = pow_low_q;
    pow_cold_d      = pow_cold_q;
    lim_med_d       = lim_med_q;
    lim_crit_d      = lim_crit_q;
    phase_d         = phase_q;
    temp_d          = temp_q;
    ref_d           = ref_q;
    period_d        = period_q;
    motor_d         = motor_q;
    heater_d        = heater_q;
    cooler_d        = cooler_q;
    result_o        = '0;

    case (item_i.operation)
      OP_COMMAND: begin
        case (item_i.command_code)
          CMD_VERSION: begin
            result_o.message_kind = MSG_REPLY;
            result_o.reply_kind   = CMD_VERSION;
            result_o.reply_high   = VERSION_HIGH;
          end
          CMD_RUN_FWD, CMD_RUN_REV: begin
            motor_d = drive_f(item_i.arg_first, item_i.command_code == CMD_RUN_REV,
                              period_q);
            if (item_i.arg_first != 8'd0) begin
              motor_reverse_d = item_i.command_code == CMD_RUN_REV;
            end
          end
          CMD_SETPOS: pos_d = set_wide[PW-1:0];
          CMD_POS_READ: begin
            result_o.message_kind = MSG_REPLY;
            result_o.reply_kind   = CMD_POS_READ;
            result_o.reply_low    = pos_wide[7:0];
            result_o.reply_high   = pos_wide[15:8];
          end
          CMD_GOTO: begin
            goal_d = seek_goal;
            if (seek_goal != pos_q) begin
              seek_rate_d = item_i.arg_first;
              motor_d     = drive_f(item_i.arg_first, seek_dir, period_q);
              if (item_i.arg_first != 8'd0) begin
                motor_reverse_d = seek_dir;
              end
            end
          end
          CMD_COAST:      motor_d = MOTOR_OFF;
          CMD_ALERT_ADDR: notify_addr_d = item_i.arg_first;
          CMD_MAT_QUERY: begin
            result_o.message_kind = MSG_REPLY;
            result_o.reply_kind   = CMD_MAT_QUERY;
            result_o.reply_low    = {7'd0, ~item_i.material_level};
          end
          CMD_HEAT_CFG: begin
            pow_low_d  = item_i.arg_first;
            pow_cold_d = item_i.arg_second;
            lim_med_d  = item_i.arg_third;
            lim_crit_d = item_i.arg_fourth;
          end
          CMD_TEMP_READ: begin
            result_o.message_kind = MSG_REPLY;
            result_o.reply_kind   = CMD_TEMP_READ;
            result_o.reply_low    = temp_q;
            result_o.reply_high   = ref_q;
          end
          CMD_FAN_SET: cooler_d = item_i.arg_first != 8'd0;
          CMD_PWM_PERIOD: begin
            period_d           = item_i.arg_first;
            motor_d.period_now = item_i.arg_first;
          end
          default: ;
        endcase
      end
      OP_HEAT_TICK: begin
        if (temp_q <= lim_crit_q) begin
          heater_d = 1'b0;
        end else if (temp_q <= lim_med_q && phase_q >= pow_low_q && pow_low_q != BYTE_MAX) begin
          heater_d = 1'b0;
        end else if (temp_q > lim_med_q && phase_q >= pow_cold_q
                     && pow_cold_q != BYTE_MAX) begin
          heater_d = 1'b0;
        end else begin
          heater_d = 1'b1;
        end
        phase_d = phase_q + 8'd1;
      end
      OP_PIN_SAMPLE: begin
        if (item_i.opto_level && !prev_opto_q) begin
          pos_d = pos_step;
          if (seek_rate_q != 8'd0 && pos_step == goal_q) begin
            seek_rate_d = 8'd0;
            motor_d     = MOTOR_OFF;
          end
        end
        if (!item_i.material_level && prev_mat_q && notify_addr_q != NOTIFY_RESET) begin
          result_o.message_kind  = MSG_NOTIFY;
          result_o.notify_target = notify_addr_q;
          result_o.reply_kind    = CMD_MAT_QUERY;
          result_o.reply_low     = EMPTY_FLAG;
        end
        prev_opto_d = item_i.opto_level;
        prev_mat_d  = item_i.material_level;
      end
      default: begin
        temp_d = item_i.temperature_count;
        ref_d  = item_i.reference_count;
      end
    endcase

    result_o.motor     = motor_d;
    result_o.heater_on = heater_d;
    result_o.cooler_on = cooler_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_reverse_q <= 1'b0;
      seek_rate_q     <= 8'd0;
      notify_addr_q   <= NOTIFY_RESET;
      prev_opto_q     <= 1'b0;
      prev_mat_q      <= 1'b0;
      pos_q           <= '0;
      goal_q          <= '0;
      pow_low_q       <= 8'd0;
      pow_cold_q      <= 8'd0;
      lim_med_q       <= 8'd0;
      lim_crit_q      <= 8'd0;
      phase_q         <= 8'd0;
      temp_q          <= 8'd0;
      ref_q           <= 8'd0;
      period_q        <= PERIOD_RESET;
      motor_q         <= MOTOR_OFF;
      heater_q        <= 1'b0;
      cooler_q        <= 1'b0;
    end else if (step_i) begin
      motor_reverse_q <= motor_reverse_d;
      seek_rate_q     <= seek_rate_d;
      notify_addr_q   <= notify_addr_d;
      prev_opto_q     <= prev_opto_d;
      prev_mat_q      <= prev_mat_d;
      pos_q           <= pos_d;
      goal_q          <= goal_d;
      pow_low_q       <= pow_low_d;
      pow_cold_q      <= pow_cold_d;
      lim_med_q       <= lim_med_d;
      lim_crit_q      <= lim_crit_d;
      phase_q         <= phase_d;
      temp_q          <= temp_d;
      ref_q           <= ref_d;
      period_q        <= period_d;
      motor_q         <= motor_d;
      heater_q        <= heater_d;
      cooler_q        <= cooler_d;
    end
  end

endmodule

// ===== sv/extruder_motor_heater_controller_unit.sv =====
`timescale 1ns / 1ps
// Extruder motor and heater controller: input register, decision core and
// result register. Depends on emhc_pkg, emhc_in_if, emhc_out_if, emhc_core.
//
// Usage:
//   in_i carries one item per handshake: a host command with four argument
//   bytes, a heater tick, a sample of the opto and material pins, or a new
//   temperature measurement. out_o returns exactly one result per item:
//   an optional reply or notification plus the motor, heater and cooler
//   outputs as they stand after that item.
//   From the input handshake an item waits in the input register, then passes
//   through the decision logic into the result register; out_o.valid rises
//   when the result register is loaded, which waits while out_o stalls.
//   Throughput is one item per cycle while out_o does not stall, set by the
//   single decision pass over the controller state registers.
//   When out_o stalls, one result waits in the result register and one item
//   waits in the input register; in_i.ready then drops until the result is
//   taken. No item is lost or repeated.
//   Reset empties both registers and returns the state to motor off with
//   period 255, notify address 255, heater and cooler off, position zero.
module extruder_motor_heater_controller_unit #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  emhc_in_if.sink      in_i,
  emhc_out_if.source   out_o
);
  import emhc_pkg::*;

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t result;
  logic      step;
  logic      in_take;

  assign step     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;
  assign in_take  = in_i.valid && in_i.ready;

  emhc_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.operation         <= in_i.operation;
      in_q.command_code      <= in_i.command_code;
      in_q.arg_first         <= in_i.arg_first;
      in_q.arg_second        <= in_i.arg_second;
      in_q.arg_third         <= in_i.arg_third;
      in_q.arg_fourth        <= in_i.arg_fourth;
      in_q.opto_level        <= in_i.opto_level;
      in_q.material_level    <= in_i.material_level;
      in_q.temperature_count <= in_i.temperature_count;
      in_q.reference_count   <= in_i.reference_count;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.message_kind   = out_q.message_kind;
  assign out_o.notify_target  = out_q.notify_target;
  assign out_o.reply_kind     = out_q.reply_kind;
  assign out_o.reply_low      = out_q.reply_low;
  assign out_o.reply_high     = out_q.reply_high;
  assign out_o.forward_enable = out_q.motor.fwd;
  assign out_o.reverse_enable = out_q.motor.rev;
  assign out_o.pwm_enable     = out_q.motor.pwm_on;
  assign out_o.pwm_duty       = out_q.motor.duty;
  assign out_o.pwm_period_now = out_q.motor.period_now;
  assign out_o.heater_on      = out_q.heater_on;
  assign out_o.cooler_on      = out_q.cooler_on;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for extruder_motor_heater_controller_unit: directed and
// random commands, heater ticks, pin samples and temperature items against a predictor.
// Depends on emhc_pkg, emhc_in_if, emhc_out_if and the controller RTL.
module tb_top;
  import emhc_pkg::*;

  localparam int POS_W      = 16;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1ns clk_i = ~clk_i;

  emhc_in_if  in_if ();
  emhc_out_if out_if ();

  extruder_motor_heater_controller_unit #(
    .POSITION_WIDTH(POS_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  localparam logic [7:0] CODE_POOL [0:12] = '{
    CMD_VERSION, CMD_RUN_FWD, CMD_RUN_REV, CMD_SETPOS, CMD_POS_READ, CMD_GOTO, CMD_COAST,
    CMD_ALERT_ADDR, CMD_MAT_QUERY, CMD_HEAT_CFG, CMD_TEMP_READ, CMD_FAN_SET, CMD_PWM_PERIOD
  };
  localparam logic [7:0] CMD_UNUSED_LO = 8'd51;
  localparam logic [7:0] CMD_UNUSED_HI = 8'd53;

  // predictor state
  logic             dir_rev;
  logic [7:0]       seek_speed;
  logic [7:0]       notify_addr;
  logic             last_opto;
  logic             last_material;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] goal;
  logic [7:0]       pwr_low;
  logic [7:0]       pwr_cold;
  logic [7:0]       lim_med;
  logic [7:0]       lim_crit;
  logic [7:0]       phase;
  logic [7:0]       temp_meas;
  logic [7:0]       ref_meas;
  logic [7:0]       period_cfg;
  motor_t           motor;
  logic             heater;
  logic             cooler;

  out_item_t predicted_outputs [$];
  int        mismatches = 0;
  int        n_sent     = 0;
  int        cycles     = 0;
  bit        no_idle    = 1'b0;

  task automatic reset_controller();
    dir_rev       = 1'b0;
    seek_speed    = '0;
    notify_addr   = NOTIFY_RESET;
    last_opto     = 1'b0;
    last_material = 1'b0;
    pos           = '0;
    goal          = '0;
    pwr_low       = '0;
    pwr_cold      = '0;
    lim_med       = '0;
    lim_crit      = '0;
    phase         = '0;
    temp_meas     = '0;
    ref_meas      = '0;
    period_cfg    = PERIOD_RESET;
    motor         = MOTOR_OFF;
    heater        = 1'b0;
    cooler        = 1'b0;
  endtask

  task automatic run_motor(logic [7:0] speed, logic dir);
    if (speed == 8'd0) begin
      motor = MOTOR_OFF;
    end else begin
      motor.fwd        = ~dir;
      motor.rev        = dir;
      motor.pwm_on     = 1'b1;
      motor.duty       = speed;
      motor.period_now = (speed == BYTE_MAX) ? 8'd0 : period_cfg;
      dir_rev          = dir;
    end
  endtask

  task automatic step_controller(input in_item_t it, output out_item_t res);
    res = '0;
    res.message_kind = MSG_NONE;
    case (op_e'(it.operation))
      OP_COMMAND: begin
        case (it.command_code)
          CMD_VERSION: begin
            res.message_kind = MSG_REPLY;
            res.reply_kind   = CMD_VERSION;
            res.reply_high   = VERSION_HIGH;
          end
          CMD_RUN_FWD: run_motor(it.arg_first, 1'b0);
          CMD_RUN_REV: run_motor(it.arg_first, 1'b1);
          CMD_SETPOS:  pos = POS_W'({it.arg_second, it.arg_first});
          CMD_POS_READ: begin
            res.message_kind = MSG_REPLY;
            res.reply_kind   = CMD_POS_READ;
            res.reply_low    = pos[7:0];
            res.reply_high   = pos[15:8];
          end
          CMD_GOTO: begin
            goal = POS_W'({it.arg_third, it.arg_second});
            if (goal != pos) begin
              seek_speed = it.arg_first;
              run_motor(seek_speed, $signed(pos) > $signed(goal));
            end
          end
          CMD_COAST:      run_motor(8'd0, 1'b0);
          CMD_ALERT_ADDR: notify_addr = it.arg_first;
          CMD_MAT_QUERY: begin
            res.message_kind = MSG_REPLY;
            res.reply_kind   = CMD_MAT_QUERY;
            res.reply_low    = it.material_level ? 8'd0 : EMPTY_FLAG;
          end
          CMD_HEAT_CFG: begin
            pwr_low  = it.arg_first;
            pwr_cold = it.arg_second;
            lim_med  = it.arg_third;
            lim_crit = it.arg_fourth;
          end
          CMD_TEMP_READ: begin
            res.message_kind = MSG_REPLY;
            res.reply_kind   = CMD_TEMP_READ;
            res.reply_low    = temp_meas;
            res.reply_high   = ref_meas;
          end
          CMD_FAN_SET: cooler = (it.arg_first != 8'd0);
          CMD_PWM_PERIOD: begin
            period_cfg       = it.arg_first;
            motor.period_now = it.arg_first;
          end
          default: ;
        endcase
      end
      OP_HEAT_TICK: begin
        if (temp_meas <= lim_crit) begin
          heater = 1'b0;
        end else if (temp_meas <= lim_med && phase >= pwr_low && pwr_low != BYTE_MAX) begin
          heater = 1'b0;
        end else if (temp_meas > lim_med && phase >= pwr_cold && pwr_cold != BYTE_MAX) begin
          heater = 1'b0;
        end else begin
          heater = 1'b1;
        end
        phase = phase + 8'd1;
      end
      OP_PIN_SAMPLE: begin
        if (it.opto_level && !last_opto) begin
          pos = dir_rev ? pos - 1'b1 : pos + 1'b1;
          if (seek_speed != 8'd0 && pos == goal) begin
            seek_speed = '0;
            motor      = MOTOR_OFF;
          end
        end
        if (!it.material_level && last_material && notify_addr != NOTIFY_RESET) begin
          res.message_kind  = MSG_NOTIFY;
          res.notify_target = notify_addr;
          res.reply_kind    = CMD_MAT_QUERY;
          res.reply_low     = EMPTY_FLAG;
        end
        last_opto     = it.opto_level;
        last_material = it.material_level;
      end
      default: begin
        temp_meas = it.temperature_count;
        ref_meas  = it.reference_count;
      end
    endcase
    res.motor     = motor;
    res.heater_on = heater;
    res.cooler_on = cooler;
  endtask

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    it.operation = 2'($urandom_range(0, 3));
    if (r < 70) begin
      it.command_code = CODE_POOL[4'($urandom_range(0, 12))];
    end else if (r < 76) begin
      it.command_code = 8'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    end else begin
      it.command_code = 8'($urandom_range(0, 255));
    end
    it.arg_first         = 8'($urandom_range(0, 255));
    it.arg_second        = 8'($urandom_range(0, 255));
    it.arg_third         = 8'($urandom_range(0, 255));
    it.arg_fourth        = 8'($urandom_range(0, 255));
    it.opto_level        = 1'($urandom_range(0, 1));
    it.material_level    = 1'($urandom_range(0, 1));
    it.temperature_count = 8'($urandom_range(0, 255));
    it.reference_count   = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int        pause;
    out_item_t want;
    pause = pick_pause();
    @(negedge clk_i);
    if (pause > 0) begin
      in_if.valid <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.operation         <= it.operation;
    in_if.command_code      <= it.command_code;
    in_if.arg_first         <= it.arg_first;
    in_if.arg_second        <= it.arg_second;
    in_if.arg_third         <= it.arg_third;
    in_if.arg_fourth        <= it.arg_fourth;
    in_if.opto_level        <= it.opto_level;
    in_if.material_level    <= it.material_level;
    in_if.temperature_count <= it.temperature_count;
    in_if.reference_count   <= it.reference_count;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    step_controller(it, want);
    predicted_outputs.push_back(want);
    n_sent++;
  endtask

  task automatic send_cmd(logic [7:0] code, logic [7:0] a1, logic [7:0] a2,
                          logic [7:0] a3, logic [7:0] a4);
    in_item_t it;
    it              = rand_item();
    it.operation    = OP_COMMAND;
    it.command_code = code;
    it.arg_first    = a1;
    it.arg_second   = a2;
    it.arg_third    = a3;
    it.arg_fourth   = a4;
    send_item(it);
  endtask

  task automatic send_pins(logic opto, logic mat);
    in_item_t it;
    it                = rand_item();
    it.operation      = OP_PIN_SAMPLE;
    it.opto_level     = opto;
    it.material_level = mat;
    send_item(it);
  endtask

  task automatic send_temp(logic [7:0] t, logic [7:0] r);
    in_item_t it;
    it                   = rand_item();
    it.operation         = OP_TEMPERATURE;
    it.temperature_count = t;
    it.reference_count   = r;
    send_item(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it           = rand_item();
    it.operation = OP_HEAT_TICK;
    send_item(it);
  endtask

  task automatic test_directed();
    send_cmd(CMD_VERSION, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_RUN_FWD, 8'd1, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_PWM_PERIOD, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_RUN_FWD, 8'd255, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_PWM_PERIOD, 8'd255, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_RUN_REV, 8'd128, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_RUN_REV, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_SETPOS, 8'd255, 8'd255, 8'd0, 8'd0);
    send_cmd(CMD_GOTO, 8'd200, 8'd255, 8'd255, 8'd0);
    send_cmd(CMD_GOTO, 8'd90, 8'd1, 8'd0, 8'd0);
    send_pins(1'b1, 1'b1);
    send_pins(1'b0, 1'b1);
    send_pins(1'b1, 1'b0);
    send_cmd(CMD_POS_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_ALERT_ADDR, 8'h5A, 8'd0, 8'd0, 8'd0);
    send_pins(1'b0, 1'b1);
    send_pins(1'b1, 1'b0);
    send_cmd(CMD_MAT_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_HEAT_CFG, 8'd255, 8'd0, 8'd200, 8'd10);
    send_temp(8'd255, 8'd0);
    send_tick();
    send_temp(8'd0, 8'd255);
    send_tick();
    send_cmd(CMD_TEMP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_FAN_SET, 8'd1, 8'd0, 8'd0, 8'd0);
    send_cmd(CMD_UNUSED_LO, 8'd255, 8'd255, 8'd255, 8'd255);
    send_cmd(8'd255, 8'd1, 8'd1, 8'd1, 8'd1);
    send_cmd(CMD_COAST, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_seek_and_count(int upto);
    int               delta;
    int               steps;
    int               r;
    logic [POS_W-1:0] dest;
    logic             mat;
    while (n_sent < upto) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        send_cmd(CMD_SETPOS, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (r == 2) begin
        send_cmd(CMD_SETPOS, 8'hFE, 8'h7F, 8'd0, 8'd0);
      end else if (r == 3) begin
        send_cmd(CMD_ALERT_ADDR, ($urandom_range(0, 2) == 0) ? NOTIFY_RESET : 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
      end
      delta = $urandom_range(0, 12) - 6;
      dest  = pos + POS_W'(delta);
      r     = $urandom_range(0, 9);
      send_cmd(CMD_GOTO, (r == 0) ? 8'd0 : (r == 1) ? BYTE_MAX : 8'($urandom_range(1, 254)),
               dest[7:0], dest[15:8], 8'($urandom));
      steps = ((delta < 0) ? -delta : delta) + $urandom_range(0, 2);
      repeat (steps) begin
        mat = ($urandom_range(0, 6) == 0) ? ~last_material : last_material;
        send_pins(1'b1, mat);
        mat = ($urandom_range(0, 6) == 0) ? ~last_material : last_material;
        send_pins(1'b0, mat);
        if ($urandom_range(0, 7) == 0) send_item(rand_item());
      end
      send_cmd(CMD_POS_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  function automatic logic [7:0] pick_power();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return BYTE_MAX;
    if (r == 2) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_heater_zones(int upto);
    logic [7:0] lc;
    logic [7:0] lm;
    logic [7:0] t;
    int         r;
    while (n_sent < upto) begin
      lc = 8'($urandom_range(0, 120));
      lm = 8'($urandom_range(0, 255));
      send_cmd(CMD_HEAT_CFG, pick_power(), pick_power(), lm, lc);
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 5);
        case (r)
          0:       t = lc;
          1:       t = lc + 8'd1;
          2:       t = lm;
          3:       t = lm + 8'd1;
          default: t = 8'($urandom_range(0, 255));
        endcase
        send_temp(t, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(4, 40)) send_tick();
        if ($urandom_range(0, 2) == 0) begin
          send_cmd(CMD_TEMP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        send_cmd(CMD_FAN_SET, ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_random_mix(int upto, bit quiet);
    no_idle = quiet;
    while (n_sent < upto) send_item(rand_item());
    no_idle = 1'b0;
  endtask

  initial begin : drive_result_ready
    int run;
    int r;
    bit level;
    run          = 0;
    level        = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (run == 0) begin
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
          level = 1'b1;
          run   = $urandom_range(1, 12);
        end else if (r < 90) begin
          level = 1'b0;
          run   = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          run   = $urandom_range(4, 20);
        end
      end
      run--;
      out_if.ready <= rst_ni ? level : 1'b0;
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (predicted_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual message_kind %0d",
                 $time, out_if.message_kind);
        mismatches++;
      end else begin
        want = predicted_outputs.pop_front();
        check_field("message_kind", 8'(want.message_kind), 8'(out_if.message_kind));
        check_field("notify_target", want.notify_target, out_if.notify_target);
        check_field("reply_kind", want.reply_kind, out_if.reply_kind);
        check_field("reply_low", want.reply_low, out_if.reply_low);
        check_field("reply_high", want.reply_high, out_if.reply_high);
        check_field("forward_enable", 8'(want.motor.fwd), 8'(out_if.forward_enable));
        check_field("reverse_enable", 8'(want.motor.rev), 8'(out_if.reverse_enable));
        check_field("pwm_enable", 8'(want.motor.pwm_on), 8'(out_if.pwm_enable));
        check_field("pwm_duty", want.motor.duty, out_if.pwm_duty);
        check_field("pwm_period_now", want.motor.period_now, out_if.pwm_period_now);
        check_field("heater_on", 8'(want.heater_on), 8'(out_if.heater_on));
        check_field("cooler_on", 8'(want.cooler_on), 8'(out_if.cooler_on));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL extruder_motor_heater_controller_unit");
      $finish;
    end
  end

  initial begin
    rst_ni                  = 1'b0;
    in_if.valid             = 1'b0;
    in_if.operation         = '0;
    in_if.command_code      = '0;
    in_if.arg_first         = '0;
    in_if.arg_second        = '0;
    in_if.arg_third         = '0;
    in_if.arg_fourth        = '0;
    in_if.opto_level        = 1'b0;
    in_if.material_level    = 1'b0;
    in_if.temperature_count = '0;
    in_if.reference_count   = '0;
    reset_controller();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_seek_and_count(600);
    test_heater_zones(1050);
    test_random_mix(1200, 1'b1);
    test_random_mix(1575, 1'b0);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS extruder_motor_heater_controller_unit");
    end else begin
      $display("FAIL extruder_motor_heater_controller_unit");
    end
    $finish;
  end

endmodule
